// ----- rtl/wsdf_pkg.sv -----
// Shared result codes and field widths for the WebSocket frame deframer.
`default_nettype none

package wsdf_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_LEN_TOP   = 2'd1;
	localparam logic [1:0] ERR_RESERVED  = 2'd2;
	localparam logic [1:0] ERR_CTRL_LONG = 2'd3;

	// Field widths.
	localparam int unsigned LEN_W = 63;

	typedef logic [LEN_W-1:0] len_t;

endpackage

`default_nettype wire

// ----- rtl/websocket_frame_deframer_unmask.sv -----
// Top level of the WebSocket frame deframer with payload unmasking.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    data_byte
// result    out        out_valid/out_ready  kind, data_byte_res, opcode, final_fragment,
//                                           masked, frame_length, error_code, last
//
// One byte is taken per cycle; its result, if any, shows in the next cycle.
// The parser state and the result register update in the same cycle, so the
// sustained rate is one byte per clock while the result side keeps up.
// When a result waits and out_ready is low, in_ready drops until it is taken.
// Reset returns the parser to waiting for a first header byte and clears halt.
// After an error every accepted byte is dropped until the next reset.
`default_nettype none

module websocket_frame_deframer_unmask (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          data_byte,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [1:0]          kind,
	output logic [7:0]          data_byte_res,
	output logic [3:0]          opcode,
	output logic                final_fragment,
	output logic                masked,
	output wsdf_pkg::len_t      frame_length,
	output logic [1:0]          error_code,
	output logic                last
);
	import wsdf_pkg::*;

	localparam logic [2:0] PH_FIRST   = 3'd0;
	localparam logic [2:0] PH_LEN     = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	localparam logic [6:0] LEN7_16    = 7'd126;
	localparam logic [6:0] LEN7_64    = 7'd127;
	localparam len_t       CTRL_MAX   = len_t'(125);

	// Parser state.
	logic [2:0]  phase_q, phase_n;
	logic [7:0]  flags_q, flags_n;
	len_t        accum_q, accum_n;
	logic [3:0]  left_q, left_n;
	logic [31:0] key_q, key_n;
	logic        mpres_q, mpres_n;
	logic [63:0] remain_q, remain_n;
	logic [1:0]  midx_q, midx_n;
	logic        halted_q, halted_n;

	// Result produced by the current transaction.
	logic        emit;
	logic [1:0]  emit_kind;
	logic [7:0]  emit_data;
	len_t        emit_len;
	logic [1:0]  emit_err;
	logic        emit_last;

	logic        in_fire;
	logic        len_done;
	logic        hdr_done;
	logic [7:0]  key_byte;

	assign in_ready = !out_valid || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Mask key byte for the current payload position, most significant first.
	always_comb begin
		case (midx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Next-state and result logic for one byte.
	always_comb begin
		phase_n   = phase_q;
		flags_n   = flags_q;
		accum_n   = accum_q;
		left_n    = left_q;
		key_n     = key_q;
		mpres_n   = mpres_q;
		remain_n  = remain_q;
		midx_n    = midx_q;
		halted_n  = halted_q;
		emit      = 1'b0;
		emit_kind = KIND_HEADER;
		emit_data = 8'd0;
		emit_len  = accum_q;
		emit_err  = ERR_NONE;
		emit_last = 1'b0;
		len_done  = 1'b0;
		hdr_done  = 1'b0;

		if (in_fire && !halted_q) begin
			case (phase_q)
				PH_FIRST: begin
					flags_n = data_byte;
					mpres_n = 1'b0;
					accum_n = '0;
					phase_n = PH_LEN;
				end
				PH_LEN: begin
					mpres_n = data_byte[7];
					accum_n = '0;
					if (data_byte[6:0] == LEN7_16) begin
						left_n  = 4'd2;
						phase_n = PH_EXTLEN;
					end else if (data_byte[6:0] == LEN7_64) begin
						left_n  = 4'd8;
						phase_n = PH_EXTLEN;
					end else begin
						accum_n  = len_t'(data_byte[6:0]);
						len_done = 1'b1;
					end
				end
				PH_EXTLEN: begin
					if (left_q == 4'd8 && data_byte[7]) begin
						halted_n  = 1'b1;
						emit      = 1'b1;
						emit_kind = KIND_ERROR;
						emit_len  = '0;
						emit_err  = ERR_LEN_TOP;
						emit_last = 1'b1;
					end else begin
						accum_n = {accum_q[LEN_W-9:0], data_byte};
						if (left_q != 4'd0) begin
							left_n = left_q - 4'd1;
						end
						if (left_n == 4'd0) begin
							len_done = 1'b1;
						end
					end
				end
				PH_MASK: begin
					key_n = {key_q[23:0], data_byte};
					if (left_q != 4'd0) begin
						left_n = left_q - 4'd1;
					end
					if (left_n == 4'd0) begin
						hdr_done = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					midx_n    = midx_q + 2'd1;
					if (remain_q != 64'd0) begin
						remain_n = remain_q - 64'd1;
					end
					emit      = 1'b1;
					emit_kind = KIND_PAYLOAD;
					emit_data = mpres_q ? (data_byte ^ key_byte) : data_byte;
					emit_len  = accum_q;
					emit_last = (remain_n == 64'd0);
					if (remain_n == 64'd0) begin
						phase_n = PH_FIRST;
					end
				end
				default: begin
					phase_n = PH_FIRST;
				end
			endcase

			// Length complete: checks in priority order, then mask or header.
			if (len_done) begin
				if (flags_n[6:4] != 3'd0) begin
					halted_n  = 1'b1;
					emit      = 1'b1;
					emit_kind = KIND_ERROR;
					emit_len  = accum_n;
					emit_err  = ERR_RESERVED;
					emit_last = 1'b1;
				end else if (flags_n[3] && accum_n > CTRL_MAX) begin
					halted_n  = 1'b1;
					emit      = 1'b1;
					emit_kind = KIND_ERROR;
					emit_len  = accum_n;
					emit_err  = ERR_CTRL_LONG;
					emit_last = 1'b1;
				end else if (mpres_n) begin
					phase_n = PH_MASK;
					left_n  = 4'd4;
					key_n   = '0;
				end else begin
					hdr_done = 1'b1;
				end
			end

			// Header complete: report it and arm the payload counter.
			if (hdr_done) begin
				remain_n  = {1'b0, accum_n};
				midx_n    = 2'd0;
				emit      = 1'b1;
				emit_kind = KIND_HEADER;
				emit_len  = accum_n;
				emit_last = (accum_n == '0);
				phase_n   = (accum_n == '0) ? PH_FIRST : PH_PAYLOAD;
			end
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			flags_q  <= '0;
			accum_q  <= '0;
			left_q   <= '0;
			key_q    <= '0;
			mpres_q  <= 1'b0;
			remain_q <= '0;
			midx_q   <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			flags_q  <= flags_n;
			accum_q  <= accum_n;
			left_q   <= left_n;
			key_q    <= key_n;
			mpres_q  <= mpres_n;
			remain_q <= remain_n;
			midx_q   <= midx_n;
			halted_q <= halted_n;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= emit;
		end
	end

	// Result payload register; loads only when a new result is produced.
	always_ff @(posedge clk) begin
		if (in_ready && emit) begin
			kind           <= emit_kind;
			data_byte_res  <= emit_data;
			opcode         <= flags_n[3:0];
			final_fragment <= flags_n[7];
			masked         <= mpres_n;
			frame_length   <= emit_len;
			error_code     <= emit_err;
			last           <= emit_last;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/wsdf_checker.sv -----
// Port-level checker for the WebSocket frame deframer, with its bind.
`default_nettype none

module wsdf_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire [1:0]           kind,
	input wire [7:0]           data_byte_res,
	input wire [1:0]           error_code,
	input wire                 last,
	input wire wsdf_pkg::len_t frame_length
);
	import wsdf_pkg::*;

	// A waiting result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte_res)
			&& $stable(frame_length))
		else $error("result changed while stalled");

	// Only the three defined kinds appear.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_HEADER || kind == KIND_PAYLOAD || kind == KIND_ERROR))
		else $error("undefined result kind");

	// An error code is present exactly on error results.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
		else $error("error code does not match kind");

	// Errors always close the frame.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> last)
		else $error("error result without last");

	// Data byte is zero outside payload results.
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PAYLOAD |-> data_byte_res == 8'd0)
		else $error("data byte set on non-payload result");

endmodule

bind websocket_frame_deframer_unmask wsdf_checker u_wsdf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.kind           (kind),
	.data_byte_res  (data_byte_res),
	.error_code     (error_code),
	.last           (last),
	.frame_length   (frame_length)
);

`default_nettype wire

// ----- tb/websocket_frame_deframer_unmask_tb.sv -----
// Self-checking testbench for the WebSocket frame deframer with payload unmasking.
`default_nettype none

module websocket_frame_deframer_unmask_tb;
	import wsdf_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int STIMULUS_BYTES = 1800;
	localparam int DRAIN_CYCLES   = 20;

	// One result transaction as seen on the output channel.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       fin;
		logic       masked;
		len_t       len;
		logic [1:0] err;
		logic       last;
	} frame_result_t;

	// Parser phases of the predictor.
	typedef enum logic [2:0] {
		PARSE_FIRST,
		PARSE_LEN,
		PARSE_EXTLEN,
		PARSE_KEY,
		PARSE_PAYLOAD
	} parse_phase_e;

	// Tracks the frame parser state and holds the results it predicts.
	class deframe_scoreboard;
		parse_phase_e    phase;
		logic [7:0]      flags;
		logic [63:0]     len_acc;
		int unsigned     len_bytes_left;
		logic [31:0]     mask_key;
		logic            key_on;
		logic [63:0]     bytes_remaining;
		logic [1:0]      key_idx;
		logic            halted;
		frame_result_t   queued_results[$];
		int              failures;

		function new();
			phase = PARSE_FIRST;
			flags = '0;
			len_acc = '0;
			len_bytes_left = 0;
			mask_key = '0;
			key_on = 1'b0;
			bytes_remaining = '0;
			key_idx = '0;
			halted = 1'b0;
			failures = 0;
		endfunction

		function void report(string msg);
			$display("ERROR: %s", msg);
			failures++;
		endfunction

		function frame_result_t make_result(logic [1:0] k, logic [7:0] d, logic [63:0] len,
			logic [1:0] e, logic l);
			frame_result_t r;
			r.kind = k;
			r.data = d;
			r.opcode = flags[3:0];
			r.fin = flags[7];
			r.masked = key_on;
			r.len = len[62:0];
			r.err = e;
			r.last = l;
			return r;
		endfunction

		function bit raise_error(logic [1:0] code, logic [63:0] len, output frame_result_t r);
			halted = 1'b1;
			r = make_result(KIND_ERROR, 8'h00, len, code, 1'b1);
			return 1'b1;
		endfunction

		// The header result closes the frame at once when it has no payload.
		function bit header_complete(output frame_result_t r);
			bytes_remaining = len_acc;
			key_idx = '0;
			if (len_acc == 0) begin
				phase = PARSE_FIRST;
				r = make_result(KIND_HEADER, 8'h00, len_acc, ERR_NONE, 1'b1);
			end else begin
				phase = PARSE_PAYLOAD;
				r = make_result(KIND_HEADER, 8'h00, len_acc, ERR_NONE, 1'b0);
			end
			return 1'b1;
		endfunction

		// Reserved bits win over the control length check; both come before the key.
		function bit length_complete(output frame_result_t r);
			if (flags[6:4] != 3'b000)
				return raise_error(ERR_RESERVED, len_acc, r);
			if (flags[3] && len_acc > 64'd125)
				return raise_error(ERR_CTRL_LONG, len_acc, r);
			if (key_on) begin
				phase = PARSE_KEY;
				len_bytes_left = 4;
				mask_key = '0;
				return 1'b0;
			end
			return header_complete(r);
		endfunction

		// Advances the parser by one accepted byte and queues any result it causes.
		function void parse_byte(logic [7:0] b);
			frame_result_t r;
			bit have;
			logic [7:0] d;
			have = 1'b0;
			if (halted)
				return;
			case (phase)
				PARSE_FIRST: begin
					flags = b;
					key_on = 1'b0;
					len_acc = '0;
					phase = PARSE_LEN;
				end
				PARSE_LEN: begin
					key_on = b[7];
					len_acc = '0;
					if (b[6:0] == 7'd126) begin
						len_bytes_left = 2;
						phase = PARSE_EXTLEN;
					end else if (b[6:0] == 7'd127) begin
						len_bytes_left = 8;
						phase = PARSE_EXTLEN;
					end else begin
						len_acc = {57'd0, b[6:0]};
						have = length_complete(r);
					end
				end
				PARSE_EXTLEN: begin
					if (len_bytes_left == 8 && b[7]) begin
						have = raise_error(ERR_LEN_TOP, 64'd0, r);
					end else begin
						len_acc = {len_acc[55:0], b};
						if (len_bytes_left > 0)
							len_bytes_left--;
						if (len_bytes_left == 0)
							have = length_complete(r);
					end
				end
				PARSE_KEY: begin
					mask_key = {mask_key[23:0], b};
					if (len_bytes_left > 0)
						len_bytes_left--;
					if (len_bytes_left == 0)
						have = header_complete(r);
				end
				PARSE_PAYLOAD: begin
					d = b;
					if (key_on)
						d = d ^ mask_key[8 * (3 - key_idx) +: 8];
					key_idx = key_idx + 2'd1;
					if (bytes_remaining > 0)
						bytes_remaining--;
					if (bytes_remaining == 0)
						phase = PARSE_FIRST;
					r = make_result(KIND_PAYLOAD, d, len_acc, ERR_NONE, bytes_remaining == 0);
					have = 1'b1;
				end
				default: phase = PARSE_FIRST;
			endcase
			if (have)
				queued_results.insert(queued_results.size(), r);
		endfunction

		function void compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		endfunction

		// Compares one result transaction with the oldest prediction.
		function void check_result(frame_result_t got);
			frame_result_t want;
			if (queued_results.size() == 0) begin
				report($sformatf("unexpected result transaction, kind %0d", got.kind));
				return;
			end
			want = queued_results.pop_front();
			compare_field("kind", 64'(got.kind), 64'(want.kind));
			compare_field("data_byte_res", 64'(got.data), 64'(want.data));
			compare_field("opcode", 64'(got.opcode), 64'(want.opcode));
			compare_field("final_fragment", 64'(got.fin), 64'(want.fin));
			compare_field("masked", 64'(got.masked), 64'(want.masked));
			compare_field("frame_length", 64'(got.len), 64'(want.len));
			compare_field("error_code", 64'(got.err), 64'(want.err));
			compare_field("last", 64'(got.last), 64'(want.last));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] kind;
	logic [7:0] data_byte_res;
	logic [3:0] opcode;
	logic       final_fragment;
	logic       masked;
	len_t       frame_length;
	logic [1:0] error_code;
	logic       last;

	deframe_scoreboard sb;
	frame_result_t     seen;
	bit                source_gaps;
	bit                sink_stalls;
	int                bytes_sent;
	int                quiet_cycles;

	websocket_frame_deframer_unmask dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.data_byte_res  (data_byte_res),
		.opcode         (opcode),
		.final_fragment (final_fragment),
		.masked         (masked),
		.frame_length   (frame_length),
		.error_code     (error_code),
		.last           (last)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Sample both channels at the rising edge; the result side is checked first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen.kind = kind;
				seen.data = data_byte_res;
				seen.opcode = opcode;
				seen.fin = final_fragment;
				seen.masked = masked;
				seen.len = frame_length;
				seen.err = error_code;
				seen.last = last;
				sb.check_result(seen);
			end
			if (in_valid && in_ready)
				sb.parse_byte(data_byte);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("websocket_frame_deframer_unmask: mismatch");
				$finish;
			end
		end
	end

	// The result side stalls in random bursts while stalls are enabled.
	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (sink_stalls && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// Presents one byte at a falling edge and holds it until the transaction completes.
	task send_byte(input logic [7:0] b);
		if (source_gaps && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Sends a header in the chosen length encoding, the key if with_key, and up to body_cap payload bytes.
	// Encoding 0 is the 7-bit length, 1 the 16-bit length, 2 the 64-bit length.
	task send_frame(input logic [7:0] first, input bit with_key, input int enc,
		input logic [63:0] len, input longint unsigned body_cap);
		longint unsigned body;
		logic [6:0] code7;
		code7 = (enc == 0) ? len[6:0] : (enc == 1) ? 7'd126 : 7'd127;
		body = (len < body_cap) ? len : body_cap;
		send_byte(first);
		send_byte({with_key, code7});
		if (enc == 1) begin
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end else if (enc == 2) begin
			for (int i = 7; i >= 0; i--)
				send_byte(len[8 * i +: 8]);
		end
		if (with_key)
			repeat (4) send_byte(8'($urandom_range(0, 255)));
		for (longint unsigned i = 0; i < body; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// A well-formed frame with random flags, opcode, key and length encoding.
	task send_random_frame();
		logic [7:0] first;
		int sel;
		int enc;
		logic [63:0] len;
		first = {1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 15))};
		sel = $urandom_range(0, 19);
		if (sel < 12) begin
			enc = 0;
			len = 64'($urandom_range(0, 24));
		end else if (sel < 14) begin
			enc = 0;
			len = 64'($urandom_range(100, 125));
		end else if (sel < 17) begin
			enc = 1;
			len = 64'($urandom_range(0, 40));
		end else if (sel < 18) begin
			enc = 1;
			len = 64'($urandom_range(126, 400));
		end else begin
			enc = 2;
			len = 64'($urandom_range(0, 24));
		end
		// Control frames stay within the allowed 125 bytes.
		if (first[3] && len > 64'd125)
			len = 64'd125;
		send_frame(first, 1'($urandom_range(0, 1)), enc, len, len);
	endtask

	// One frame that trips the selected error; the parser then ignores everything.
	task send_error_frame();
		logic [7:0] first;
		logic [63:0] len;
		int enc;
		int code;
		code = $urandom_range(1, 3);
		len = {$urandom, $urandom};
		if (code == 1) begin
			first = 8'($urandom_range(0, 255));
			enc = 2;
			len[63] = 1'b1;
		end else if (code == 2) begin
			first = {1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
				4'($urandom_range(0, 15))};
			enc = $urandom_range(0, 2);
			if (enc == 0)
				len = 64'($urandom_range(0, 125));
			else if (enc == 1)
				len = 64'(len[15:0]);
			else
				len[63] = 1'b0;
		end else begin
			first = {1'($urandom_range(0, 1)), 3'b000, 1'b1, 3'($urandom_range(0, 7))};
			enc = $urandom_range(1, 2);
			if (enc == 1)
				len = 64'($urandom_range(126, 65535));
			else
				len[63] = 1'b0;
		end
		// Occasionally push the decoded length to its largest value.
		if (enc == 2 && code != 1 && $urandom_range(0, 3) == 0)
			len = 64'h7FFF_FFFF_FFFF_FFFF;
		send_frame(first, 1'($urandom_range(0, 1)), enc, len, 4);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		source_gaps = 1'b1;
		sink_stalls = 1'b1;
		bytes_sent = 0;
		quiet_cycles = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames: empty frame, masked empty control frame, non-minimal
		// 16- and 64-bit lengths, and a masked frame that wraps the key index.
		send_frame(8'h80, 1'b0, 0, 64'd0, 64'd0);
		send_frame(8'h89, 1'b1, 0, 64'd0, 64'd0);
		send_frame(8'h01, 1'b0, 1, 64'd1, 64'd1);
		send_frame(8'h82, 1'b1, 0, 64'd5, 64'd5);
		send_frame(8'h0F, 1'b1, 2, 64'd1, 64'd1);

		// Random well-formed frames, with idling toggled between stretches.
		while (bytes_sent < STIMULUS_BYTES) begin
			if (bytes_sent >= STIMULUS_BYTES - 300) begin
				source_gaps = 1'b0;
				sink_stalls = 1'b0;
			end else if (bytes_sent >= 600 && $urandom_range(0, 3) == 0) begin
				source_gaps = $urandom_range(0, 1);
				sink_stalls = $urandom_range(0, 1);
			end
			send_random_frame();
		end

		// Finish with an error and bytes that must all be dropped.
		send_error_frame();
		repeat (16) send_byte(8'($urandom_range(0, 255)));
		in_valid = 1'b0;

		while (sb.queued_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.queued_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.queued_results.size()));
		if (sb.failures == 0)
			$display("websocket_frame_deframer_unmask: match");
		else
			$display("websocket_frame_deframer_unmask: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
